// ===== rtl/eds_pkg.sv =====
// Shared types, constants and helpers for the edit distance engine.
// No dependencies; every other file of the block refers to this package.
package eds_pkg;

   localparam int CODE_POINT_W          = 21;
   localparam int ACTION_W              = 2;
   localparam int RESULT_W              = 8;
   localparam int DEF_MAX_QUERY_LEN     = 64;
   localparam int DEF_MAX_CANDIDATE_LEN = 255;
   localparam logic MODE_RESET          = 1'b1;

   typedef enum logic [ACTION_W-1:0] {
      ACT_QUERY_APPEND = 2'd0,
      ACT_QUERY_CLEAR  = 2'd1,
      ACT_CAND_CHAR    = 2'd2,
      ACT_CAND_END     = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WAVE,
      ST_FINISH
   } state_type;

   // Broadcast from the sequencer to every column cell.
   typedef struct packed {
      logic                    restart;
      logic                    load;
      logic                    update;
      logic                    trans_ok;
      logic [CODE_POINT_W-1:0] load_char;
      logic [CODE_POINT_W-1:0] cand_char;
      logic [CODE_POINT_W-1:0] prior_char;
   } cell_ctrl_type;

   function automatic logic [RESULT_W-1:0] sat8(input logic [31:0] value);
      logic [RESULT_W-1:0] result;
      result = (value > 32'd255) ? 8'hFF : value[RESULT_W-1:0];
      return result;
   endfunction

endpackage

// ===== rtl/eds_if.sv =====
// Valid/ready channel interfaces for the request and response sides.
// Depends on eds_pkg for field widths.
interface eds_req_if;
   logic                                valid;
   logic                                ready;
   logic [eds_pkg::ACTION_W-1:0]        action;
   logic [eds_pkg::CODE_POINT_W-1:0]    code_point;
   logic                                last_char;

   modport source (output valid, action, code_point, last_char, input ready);
   modport sink   (input valid, action, code_point, last_char, output ready);
endinterface

interface eds_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [eds_pkg::RESULT_W-1:0]        distance;
   logic [eds_pkg::RESULT_W-1:0]        longer_length;
   logic [eds_pkg::RESULT_W-1:0]        candidate_length;
   logic                                query_truncated;
   logic                                candidate_truncated;

   modport source (output valid, distance, longer_length, candidate_length,
                   query_truncated, candidate_truncated, input ready);
   modport sink   (input valid, distance, longer_length, candidate_length,
                   query_truncated, candidate_truncated, output ready);
endinterface

// ===== rtl/edit_distance_osa.sv =====
// Edit distance engine (Levenshtein or optimal string alignment) top level.
// Depends on eds_pkg, eds_if (eds_req_if, eds_rsp_if) and eds_cell.
//
// The query is loaded one character per transfer into a chain of
// MAX_QUERY_LEN column cells. Each candidate character (or end-of-candidate)
// launches one wavefront that walks the whole cell chain, one column per
// cycle, computing a full table row; the next request is taken only after
// the row has left the end of the chain and its finish step has completed.
// A result sits in an output register and does not block new requests until
// the following result is ready to leave. csr_write_data selects plain
// Levenshtein (0) or optimal string alignment (1, reset value); write it only
// while the block is idle.
module edit_distance_osa #(
   parameter int MAX_QUERY_LEN     = eds_pkg::DEF_MAX_QUERY_LEN,
   parameter int MAX_CANDIDATE_LEN = eds_pkg::DEF_MAX_CANDIDATE_LEN
) (
   input  logic         clock,
   input  logic         reset,
   eds_req_if.sink      req_chan,
   eds_rsp_if.source    rsp_chan,
   input  logic         csr_write_en,
   input  logic         csr_write_data
);

   localparam int VAL_W = $clog2(MAX_CANDIDATE_LEN + MAX_QUERY_LEN + 2);
   localparam int QCW   = $clog2(MAX_QUERY_LEN + 1);
   localparam int RNW   = $clog2(MAX_CANDIDATE_LEN + 1);
   localparam logic [QCW-1:0] QC_MAX = QCW'(MAX_QUERY_LEN);
   localparam logic [RNW-1:0] RN_MAX = RNW'(MAX_CANDIDATE_LEN);

   eds_pkg::state_type state_ff, state_in;

   logic                             mode_ff, mode_in;
   logic [QCW-1:0]                   qc_ff, qc_in;
   logic                             ovf_q_ff, ovf_q_in;
   logic                             ovf_c_ff, ovf_c_in;
   logic [RNW-1:0]                   rn_ff, rn_in;
   logic [eds_pkg::CODE_POINT_W-1:0] prior_ff, prior_in;
   logic [eds_pkg::CODE_POINT_W-1:0] cand_ff, cand_in;
   logic                             upd_ff, upd_in;
   logic                             drop_ff, drop_in;
   logic                             emit_ff, emit_in;
   logic                             launch_ff, launch_in;
   logic [VAL_W-1:0]                 exit_ff, exit_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [eds_pkg::RESULT_W-1:0]     dist_ff, dist_in;
   logic [eds_pkg::RESULT_W-1:0]     longer_ff, longer_in;
   logic [eds_pkg::RESULT_W-1:0]     clen_ff, clen_in;
   logic                             qtrunc_ff, qtrunc_in;
   logic                             ctrunc_ff, ctrunc_in;

   logic                   accept;
   logic                   finish_go;
   logic                   restart;
   logic                   load;
   logic [RNW-1:0]         rn_next;
   logic [31:0]            longer_wide;
   eds_pkg::action_type    act;
   eds_pkg::cell_ctrl_type cell_ctrl;

   logic                             tok_valid [0:MAX_QUERY_LEN];
   logic [VAL_W-1:0]                 tok_cur   [0:MAX_QUERY_LEN];
   logic [VAL_W-1:0]                 tok_rp    [0:MAX_QUERY_LEN];
   logic [VAL_W-1:0]                 tok_rbp   [0:MAX_QUERY_LEN];
   logic [VAL_W-1:0]                 tok_rbp2  [0:MAX_QUERY_LEN];
   logic [eds_pkg::CODE_POINT_W-1:0] tok_char  [0:MAX_QUERY_LEN];

   assign act    = eds_pkg::action_type'(req_chan.action);
   assign accept = req_chan.valid && req_chan.ready;

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         eds_pkg::ST_IDLE: begin
            if (accept && (act == eds_pkg::ACT_CAND_CHAR || act == eds_pkg::ACT_CAND_END))
               state_in = eds_pkg::ST_WAVE;
         end
         eds_pkg::ST_WAVE: begin
            if (tok_valid[MAX_QUERY_LEN]) state_in = eds_pkg::ST_FINISH;
         end
         eds_pkg::ST_FINISH: begin
            if (finish_go) state_in = eds_pkg::ST_IDLE;
         end
         default: state_in = eds_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_chan.ready = (state_ff == eds_pkg::ST_IDLE);
      finish_go      = (state_ff == eds_pkg::ST_FINISH) &&
                       (!emit_ff || !rsp_valid_ff || rsp_chan.ready);
   end

   // ---------------- datapath next values ----------------
   always_comb begin
      mode_in      = mode_ff;
      qc_in        = qc_ff;
      ovf_q_in     = ovf_q_ff;
      ovf_c_in     = ovf_c_ff;
      rn_in        = rn_ff;
      prior_in     = prior_ff;
      cand_in      = cand_ff;
      upd_in       = upd_ff;
      drop_in      = drop_ff;
      emit_in      = emit_ff;
      launch_in    = 1'b0;
      exit_in      = tok_valid[MAX_QUERY_LEN] ? tok_cur[MAX_QUERY_LEN] : exit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      dist_in      = dist_ff;
      longer_in    = longer_ff;
      clen_in      = clen_ff;
      qtrunc_in    = qtrunc_ff;
      ctrunc_in    = ctrunc_ff;
      restart      = 1'b0;
      load         = 1'b0;
      rn_next      = upd_ff ? (rn_ff + RNW'(1)) : rn_ff;
      longer_wide  = (32'(qc_ff) > 32'(rn_next)) ? 32'(qc_ff) : 32'(rn_next);
      if (longer_wide == 32'd0) longer_wide = 32'd1;

      if (csr_write_en) mode_in = csr_write_data;

      if (accept) begin
         case (act)
            eds_pkg::ACT_QUERY_APPEND: begin
               restart  = 1'b1;
               rn_in    = '0;
               prior_in = '0;
               ovf_c_in = 1'b0;
               if (qc_ff < QC_MAX) begin
                  load  = 1'b1;
                  qc_in = qc_ff + QCW'(1);
               end else begin
                  ovf_q_in = 1'b1;
               end
            end
            eds_pkg::ACT_QUERY_CLEAR: begin
               restart  = 1'b1;
               rn_in    = '0;
               prior_in = '0;
               ovf_c_in = 1'b0;
               ovf_q_in = 1'b0;
               qc_in    = '0;
            end
            eds_pkg::ACT_CAND_CHAR: begin
               cand_in   = req_chan.code_point;
               upd_in    = (rn_ff < RN_MAX);
               drop_in   = !(rn_ff < RN_MAX);
               emit_in   = req_chan.last_char;
               launch_in = 1'b1;
            end
            eds_pkg::ACT_CAND_END: begin
               cand_in   = req_chan.code_point;
               upd_in    = 1'b0;
               drop_in   = 1'b0;
               emit_in   = 1'b1;
               launch_in = 1'b1;
            end
            default: ;
         endcase
      end

      if (finish_go) begin
         if (emit_ff) begin
            rsp_valid_in = 1'b1;
            dist_in      = eds_pkg::sat8(32'(exit_ff));
            longer_in    = eds_pkg::sat8(longer_wide);
            clen_in      = eds_pkg::sat8(32'(rn_next));
            qtrunc_in    = ovf_q_ff;
            ctrunc_in    = ovf_c_ff || drop_ff;
            restart      = 1'b1;
            rn_in        = '0;
            prior_in     = '0;
            ovf_c_in     = 1'b0;
         end else begin
            rn_in    = rn_next;
            prior_in = upd_ff ? cand_ff : prior_ff;
            ovf_c_in = ovf_c_ff || drop_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= eds_pkg::ST_IDLE;
         mode_ff      <= eds_pkg::MODE_RESET;
         qc_ff        <= '0;
         ovf_q_ff     <= 1'b0;
         ovf_c_ff     <= 1'b0;
         rn_ff        <= '0;
         prior_ff     <= '0;
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         qc_ff        <= qc_in;
         ovf_q_ff     <= ovf_q_in;
         ovf_c_ff     <= ovf_c_in;
         rn_ff        <= rn_in;
         prior_ff     <= prior_in;
         launch_ff    <= launch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff   <= cand_in;
      upd_ff    <= upd_in;
      drop_ff   <= drop_in;
      emit_ff   <= emit_in;
      exit_ff   <= exit_in;
      dist_ff   <= dist_in;
      longer_ff <= longer_in;
      clen_ff   <= clen_in;
      qtrunc_ff <= qtrunc_in;
      ctrunc_ff <= ctrunc_in;
   end

   // ---------------- column chain ----------------
   assign cell_ctrl.restart    = restart;
   assign cell_ctrl.load       = load;
   assign cell_ctrl.update     = upd_ff;
   assign cell_ctrl.trans_ok   = mode_ff && (rn_ff != '0);
   assign cell_ctrl.load_char  = req_chan.code_point;
   assign cell_ctrl.cand_char  = cand_ff;
   assign cell_ctrl.prior_char = prior_ff;

   // column zero of the table: row index before and after this row
   assign tok_valid[0] = launch_ff;
   assign tok_cur[0]   = VAL_W'(rn_ff) + VAL_W'(upd_ff);
   assign tok_rp[0]    = VAL_W'(rn_ff);
   assign tok_rbp[0]   = (rn_ff == '0) ? '0 : (VAL_W'(rn_ff) - VAL_W'(1));
   assign tok_rbp2[0]  = '0;
   assign tok_char[0]  = '0;

   for (genvar g = 1; g <= MAX_QUERY_LEN; g++) begin : g_col
      eds_cell #(
         .MAX_QUERY_LEN     (MAX_QUERY_LEN),
         .MAX_CANDIDATE_LEN (MAX_CANDIDATE_LEN),
         .CELL_INDEX        (g)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (cell_ctrl),
         .query_count (qc_ff),
         .in_valid    (tok_valid[g-1]),
         .in_cur      (tok_cur[g-1]),
         .in_rp       (tok_rp[g-1]),
         .in_rbp      (tok_rbp[g-1]),
         .in_rbp2     (tok_rbp2[g-1]),
         .in_char     (tok_char[g-1]),
         .out_valid   (tok_valid[g]),
         .out_cur     (tok_cur[g]),
         .out_rp      (tok_rp[g]),
         .out_rbp     (tok_rbp[g]),
         .out_rbp2    (tok_rbp2[g]),
         .out_char    (tok_char[g])
      );
   end

   assign rsp_chan.valid               = rsp_valid_ff;
   assign rsp_chan.distance            = dist_ff;
   assign rsp_chan.longer_length       = longer_ff;
   assign rsp_chan.candidate_length    = clen_ff;
   assign rsp_chan.query_truncated     = qtrunc_ff;
   assign rsp_chan.candidate_truncated = ctrunc_ff;

`ifndef SYNTHESIS
   a_exit_in_wave : assert property (@(posedge clock) disable iff (reset)
      tok_valid[MAX_QUERY_LEN] |-> (state_ff == eds_pkg::ST_WAVE))
      else $error("wavefront left the chain outside a row pass");

   a_launch_in_wave : assert property (@(posedge clock) disable iff (reset)
      launch_ff |-> (state_ff == eds_pkg::ST_WAVE))
      else $error("row launched while sequencer not in row pass");

   a_new_result_from_finish : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(state_ff == eds_pkg::ST_FINISH))
      else $error("result appeared without a finished row");

   a_counts_in_range : assert property (@(posedge clock) disable iff (reset)
      (qc_ff <= QC_MAX) && (rn_ff <= RN_MAX))
      else $error("query or candidate count beyond capacity");
`endif

endmodule

// ===== rtl/eds_cell.sv =====
// One query column of the edit distance table: holds a query character and
// two rows of table entries, and passes the row wavefront to its right neighbor.
// Depends on eds_pkg.
module eds_cell #(
   parameter int MAX_QUERY_LEN     = eds_pkg::DEF_MAX_QUERY_LEN,
   parameter int MAX_CANDIDATE_LEN = eds_pkg::DEF_MAX_CANDIDATE_LEN,
   parameter int CELL_INDEX        = 1,
   localparam int VAL_W = $clog2(MAX_CANDIDATE_LEN + MAX_QUERY_LEN + 2),
   localparam int QCW   = $clog2(MAX_QUERY_LEN + 1)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  eds_pkg::cell_ctrl_type               ctrl,
   input  logic [QCW-1:0]                       query_count,
   // wavefront from the left neighbor
   input  logic                                 in_valid,
   input  logic [VAL_W-1:0]                     in_cur,
   input  logic [VAL_W-1:0]                     in_rp,
   input  logic [VAL_W-1:0]                     in_rbp,
   input  logic [VAL_W-1:0]                     in_rbp2,
   input  logic [eds_pkg::CODE_POINT_W-1:0]     in_char,
   // wavefront to the right neighbor
   output logic                                 out_valid,
   output logic [VAL_W-1:0]                     out_cur,
   output logic [VAL_W-1:0]                     out_rp,
   output logic [VAL_W-1:0]                     out_rbp,
   output logic [VAL_W-1:0]                     out_rbp2,
   output logic [eds_pkg::CODE_POINT_W-1:0]     out_char
);

   localparam logic [QCW-1:0]   IDX     = QCW'(CELL_INDEX);
   localparam logic [QCW-1:0]   SLOT    = QCW'(CELL_INDEX - 1);
   localparam logic [VAL_W-1:0] INIT    = VAL_W'(CELL_INDEX);
   localparam logic             HAS_TWO = (CELL_INDEX > 1);

   logic [eds_pkg::CODE_POINT_W-1:0] char_ff, char_in;
   logic [VAL_W-1:0]                 rp_ff, rp_in;
   logic [VAL_W-1:0]                 rbp_ff, rbp_in;
   logic                             valid_ff, valid_in;
   logic [VAL_W-1:0]                 cur_ff, cur_in;
   logic [VAL_W-1:0]                 orp_ff, orp_in;
   logic [VAL_W-1:0]                 orbp_ff, orbp_in;
   logic [VAL_W-1:0]                 orbp2_ff, orbp2_in;
   logic [eds_pkg::CODE_POINT_W-1:0] ochar_ff, ochar_in;

   logic             active;
   logic [VAL_W-1:0] sub_cost, ins_cost, del_cost, trn_cost, best, best2;
   logic             trans_hit;

   assign active = (IDX <= query_count);

   always_comb begin
      sub_cost = in_rp + VAL_W'(ctrl.cand_char != char_ff);
      ins_cost = in_cur + VAL_W'(1);
      del_cost = rp_ff + VAL_W'(1);
      trn_cost = in_rbp2 + VAL_W'(1);
      best     = sub_cost;
      if (ins_cost < best) best = ins_cost;
      if (del_cost < best) best = del_cost;
      // adjacent swap: candidate "ba" against query "ab"
      trans_hit = ctrl.trans_ok && HAS_TWO && (ctrl.cand_char == in_char) &&
                  (ctrl.prior_char == char_ff) && (trn_cost < best);
      best2 = trans_hit ? trn_cost : best;
   end

   always_comb begin
      char_in = char_ff;
      rp_in   = rp_ff;
      rbp_in  = rbp_ff;
      if (ctrl.load && (SLOT == query_count)) char_in = ctrl.load_char;
      if (ctrl.restart) begin
         rp_in  = INIT;
         rbp_in = INIT;
      end else if (in_valid && ctrl.update && active) begin
         rp_in  = best2;
         rbp_in = rp_ff;
      end
      valid_in = in_valid;
      // columns past the query just forward the value toward the far end
      if (!active) cur_in = in_cur;
      else if (ctrl.update) cur_in = best2;
      else cur_in = rp_ff;
      orp_in   = rp_ff;
      orbp_in  = rbp_ff;
      orbp2_in = in_rbp;
      ochar_in = char_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rp_ff    <= INIT;
         rbp_ff   <= INIT;
         valid_ff <= 1'b0;
      end else begin
         rp_ff    <= rp_in;
         rbp_ff   <= rbp_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff  <= char_in;
      cur_ff   <= cur_in;
      orp_ff   <= orp_in;
      orbp_ff  <= orbp_in;
      orbp2_ff <= orbp2_in;
      ochar_ff <= ochar_in;
   end

   assign out_valid = valid_ff;
   assign out_cur   = cur_ff;
   assign out_rp    = orp_ff;
   assign out_rbp   = orbp_ff;
   assign out_rbp2  = orbp2_ff;
   assign out_char  = ochar_ff;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for edit_distance_osa: edit distance between the held query and
// streamed candidates, in both modes. Depends on eds_pkg, eds_req_if and eds_rsp_if.
module testbench;

   localparam int QUERY_CAP    = eds_pkg::DEF_MAX_QUERY_LEN;
   localparam int CAND_CAP     = eds_pkg::DEF_MAX_CANDIDATE_LEN;
   localparam int ITEM_TARGET  = 1900;
   localparam int QUIET_CYCLES = QUERY_CAP + 16;
   localparam int STALL_LIMIT  = 4000;

   typedef struct packed {
      logic [eds_pkg::RESULT_W-1:0] distance;
      logic [eds_pkg::RESULT_W-1:0] longer_length;
      logic [eds_pkg::RESULT_W-1:0] candidate_length;
      logic                         query_truncated;
      logic                         candidate_truncated;
   } match_score_type;

   logic clock;
   logic reset;
   logic csr_write_en;
   logic csr_write_data;

   eds_req_if req_chan();
   eds_rsp_if rsp_chan();

   edit_distance_osa #(
      .MAX_QUERY_LEN     (QUERY_CAP),
      .MAX_CANDIDATE_LEN (CAND_CAP)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   // Distance model state
   logic [eds_pkg::CODE_POINT_W-1:0] query_chars [QUERY_CAP];
   int                               query_len;
   int                               last_row  [QUERY_CAP+1];
   int                               older_row [QUERY_CAP+1];
   logic [eds_pkg::CODE_POINT_W-1:0] prev_cand_char;
   int                               rows_done;
   bit                               query_cut;
   bit                               cand_cut;
   bit                               osa_mode;

   match_score_type scores_due[$];
   match_score_type want;
   int              failures;
   int              items_sent;
   int              idle_cycles;
   int              stall_left;
   bit              steady;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [eds_pkg::RESULT_W-1:0] clip8(int v);
      return (v > 255) ? 8'hFF : v[7:0];
   endfunction

   function automatic void clear_candidate_rows();
      for (int j = 0; j <= QUERY_CAP; j++) begin
         last_row[j]  = j;
         older_row[j] = j;
      end
      prev_cand_char = '0;
      rows_done      = 0;
      cand_cut       = 1'b0;
   endfunction

   // One accepted item: update the model and queue any score it produces.
   function automatic void advance_distance_model(eds_pkg::action_type act,
                                                  logic [eds_pkg::CODE_POINT_W-1:0] cp,
                                                  logic last);
      int cur [QUERY_CAP+1];
      int row;
      int v;
      int longer;
      match_score_type s;
      case (act)
         eds_pkg::ACT_QUERY_APPEND: begin
            clear_candidate_rows();
            if (query_len < QUERY_CAP) begin
               query_chars[query_len] = cp;
               query_len++;
            end else begin
               query_cut = 1'b1;
            end
         end
         eds_pkg::ACT_QUERY_CLEAR: begin
            clear_candidate_rows();
            query_len = 0;
            query_cut = 1'b0;
         end
         default: begin
            if (act == eds_pkg::ACT_CAND_CHAR) begin
               if (rows_done < CAND_CAP) begin
                  row    = rows_done + 1;
                  cur[0] = row;
                  for (int j = 1; j <= query_len; j++) begin
                     v = last_row[j-1] + ((cp == query_chars[j-1]) ? 0 : 1);
                     if (cur[j-1] + 1 < v) v = cur[j-1] + 1;
                     if (last_row[j] + 1 < v) v = last_row[j] + 1;
                     // adjacent swap: this char matches the column before,
                     // the previous char matches this column
                     if (osa_mode && row > 1 && j > 1 && cp == query_chars[j-2] &&
                         prev_cand_char == query_chars[j-1] && older_row[j-2] + 1 < v)
                        v = older_row[j-2] + 1;
                     cur[j] = v;
                  end
                  for (int j = 0; j <= query_len; j++) begin
                     older_row[j] = last_row[j];
                     last_row[j]  = cur[j];
                  end
                  prev_cand_char = cp;
                  rows_done      = row;
               end else begin
                  cand_cut = 1'b1;
               end
            end
            if (act == eds_pkg::ACT_CAND_END || last) begin
               longer = (query_len > rows_done) ? query_len : rows_done;
               if (longer < 1) longer = 1;
               s.distance            = clip8(last_row[query_len]);
               s.longer_length       = clip8(longer);
               s.candidate_length    = clip8(rows_done);
               s.query_truncated     = query_cut;
               s.candidate_truncated = cand_cut;
               scores_due = {scores_due, s};
               clear_candidate_rows();
            end
         end
      endcase
   endfunction

   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(30, 90);
   endfunction

   // Valid stays high after a transfer; the next call either keeps it up
   // with a new item or drops it for a gap.
   task automatic send_item(eds_pkg::action_type act,
                            logic [eds_pkg::CODE_POINT_W-1:0] cp, logic last);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.action     <= act;
      req_chan.code_point <= cp;
      req_chan.last_char  <= last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      advance_distance_model(act, cp, last);
      items_sent++;
   endtask

   // Drop valid, wait for all scores, then let any wavefront in flight finish.
   task automatic settle();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (scores_due.size() != 0) @(negedge clock);
      repeat (QUIET_CYCLES) @(negedge clock);
   endtask

   task automatic write_mode(bit m);
      settle();
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= m;
      @(negedge clock);
      csr_write_en   <= 1'b0;
      osa_mode = m;
   endtask

   task automatic load_query(string s);
      send_item(eds_pkg::ACT_QUERY_CLEAR, '0, 1'b0);
      for (int i = 0; i < s.len(); i++)
         send_item(eds_pkg::ACT_QUERY_APPEND, {13'd0, s[i]}, 1'b0);
   endtask

   task automatic send_word(string s, bit close_with_end);
      for (int i = 0; i < s.len(); i++)
         send_item(eds_pkg::ACT_CAND_CHAR, {13'd0, s[i]},
                   !close_with_end && i == s.len() - 1);
      if (close_with_end || s.len() == 0)
         send_item(eds_pkg::ACT_CAND_END, '0, 1'b0);
   endtask

   task automatic test_empty_strings();
      send_item(eds_pkg::ACT_CAND_END, '0, 1'b0);
      send_item(eds_pkg::ACT_CAND_CHAR, 21'h1FFFFF, 1'b1);
   endtask

   task automatic test_code_point_extremes();
      send_item(eds_pkg::ACT_QUERY_CLEAR, '0, 1'b0);
      send_item(eds_pkg::ACT_QUERY_APPEND, 21'h000000, 1'b0);
      send_item(eds_pkg::ACT_QUERY_APPEND, 21'h1FFFFF, 1'b0);
      send_item(eds_pkg::ACT_QUERY_APPEND, 21'h10FFFF, 1'b0);
      send_item(eds_pkg::ACT_CAND_CHAR, 21'h000000, 1'b0);
      send_item(eds_pkg::ACT_CAND_CHAR, 21'h1FFFFF, 1'b1);
      send_item(eds_pkg::ACT_CAND_CHAR, 21'h155555, 1'b0);
      send_item(eds_pkg::ACT_CAND_CHAR, 21'h0AAAAA, 1'b0);
      send_item(eds_pkg::ACT_CAND_END, 21'h1FFFFF, 1'b1);
   endtask

   task automatic test_transpositions();
      for (int m = 0; m < 2; m++) begin
         write_mode(m[0]);
         load_query("abcd");
         send_word("bacd", 1'b0);
         send_word("acbd", 1'b1);
         send_word("ab", 1'b0);
      end
   endtask

   task automatic test_mode_mid_candidate();
      load_query("abc");
      send_item(eds_pkg::ACT_CAND_CHAR, 21'("b"), 1'b0);
      write_mode(1'b0);
      send_item(eds_pkg::ACT_CAND_CHAR, 21'("a"), 1'b0);
      send_item(eds_pkg::ACT_CAND_CHAR, 21'("c"), 1'b1);
      send_item(eds_pkg::ACT_CAND_CHAR, 21'("b"), 1'b0);
      write_mode(1'b1);
      send_item(eds_pkg::ACT_CAND_CHAR, 21'("a"), 1'b0);
      send_item(eds_pkg::ACT_CAND_CHAR, 21'("c"), 1'b1);
   endtask

   task automatic test_abandon_and_end();
      load_query("xy");
      send_item(eds_pkg::ACT_CAND_CHAR, 21'("x"), 1'b0);
      send_item(eds_pkg::ACT_QUERY_APPEND, 21'("z"), 1'b0);
      send_word("xyz", 1'b0);
      send_item(eds_pkg::ACT_CAND_CHAR, 21'("q"), 1'b0);
      send_item(eds_pkg::ACT_QUERY_CLEAR, '0, 1'b0);
      send_item(eds_pkg::ACT_CAND_END, '0, 1'b0);
      load_query("kitten");
      send_word("sitting", 1'b1);
   endtask

   task automatic test_query_overflow();
      send_item(eds_pkg::ACT_QUERY_CLEAR, '0, 1'b0);
      for (int i = 0; i < QUERY_CAP + 3; i++)
         send_item(eds_pkg::ACT_QUERY_APPEND, 21'($urandom_range(97, 100)), 1'b0);
      send_word("ab", 1'b0);
      send_word("", 1'b1);
      load_query("a");
      send_word("a", 1'b0);
   endtask

   task automatic test_candidate_overflow();
      load_query("ab");
      for (int i = 0; i < CAND_CAP + 3; i++)
         send_item(eds_pkg::ACT_CAND_CHAR, (i % 2) ? 21'("b") : 21'("a"),
                   i == CAND_CAP + 2);
      send_word("ba", 1'b0);
      for (int i = 0; i < CAND_CAP + 1; i++)
         send_item(eds_pkg::ACT_CAND_CHAR, 21'("a"), 1'b0);
      send_item(eds_pkg::ACT_CAND_END, '0, 1'b0);
   endtask

   function automatic logic [eds_pkg::CODE_POINT_W-1:0] pick_char();
      int r;
      r = $urandom_range(0, 9);
      if (r < 5 && query_len > 0) return query_chars[$urandom_range(0, query_len - 1)];
      if (r < 8) return 21'(97 + $urandom_range(0, 3));
      return 21'($urandom());
   endfunction

   task automatic test_random();
      int r;
      int n;
      while (items_sent < ITEM_TARGET) begin
         steady = ($urandom_range(0, 5) == 0);
         r = $urandom_range(0, 99);
         if (r < 5) begin
            write_mode(1'($urandom_range(0, 1)));
         end else if (r < 20) begin
            r = $urandom_range(0, 99);
            n = (r < 80) ? $urandom_range(0, 8) :
                (r < 95) ? $urandom_range(9, 30) : $urandom_range(60, 70);
            send_item(eds_pkg::ACT_QUERY_CLEAR, 21'($urandom()),
                      1'($urandom_range(0, 1)));
            for (int i = 0; i < n; i++)
               send_item(eds_pkg::ACT_QUERY_APPEND, ($urandom_range(0, 3) == 0) ?
                         21'($urandom()) : 21'(97 + $urandom_range(0, 3)),
                         1'($urandom_range(0, 1)));
         end else if (r < 90) begin
            r = $urandom_range(0, 99);
            n = (r < 85) ? $urandom_range(0, 8) : $urandom_range(9, 30);
            r = $urandom_range(0, 9);
            for (int i = 0; i < n; i++)
               send_item(eds_pkg::ACT_CAND_CHAR, pick_char(), r >= 3 && i == n - 1);
            if (r < 3 || n == 0)
               send_item(eds_pkg::ACT_CAND_END, 21'($urandom()),
                         1'($urandom_range(0, 1)));
         end else begin
            for (int i = $urandom_range(1, 4); i > 0; i--)
               send_item(eds_pkg::action_type'($urandom_range(0, 3)), 21'($urandom()),
                         1'($urandom_range(0, 1)));
         end
      end
      steady = 1'b0;
   endtask

   // Result side: random back-pressure
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left--;
      end else begin
         stall_left = pick_gap();
         rsp_chan.ready <= (stall_left == 0);
         if (stall_left > 0) stall_left--;
      end
   end

   task automatic report_field(string name, int expected_val, int actual_val);
      if (expected_val != actual_val) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d",
                  $time, name, expected_val, actual_val);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (scores_due.size() == 0) begin
            $display("%0t: result with none expected: distance %0d", $time,
                     rsp_chan.distance);
            failures++;
         end else begin
            want = scores_due.pop_front();
            report_field("distance", int'(want.distance), int'(rsp_chan.distance));
            report_field("longer_length", int'(want.longer_length),
                         int'(rsp_chan.longer_length));
            report_field("candidate_length", int'(want.candidate_length),
                         int'(rsp_chan.candidate_length));
            report_field("query_truncated", int'(want.query_truncated),
                         int'(rsp_chan.query_truncated));
            report_field("candidate_truncated", int'(want.candidate_truncated),
                         int'(rsp_chan.candidate_truncated));
         end
      end
   end

   // Watchdog: cycles without any transfer on either channel
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: timeout, %0d results outstanding", $time, scores_due.size());
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      reset               = 1'b1;
      csr_write_en        = 1'b0;
      csr_write_data      = 1'b0;
      req_chan.valid      = 1'b0;
      req_chan.action     = eds_pkg::ACT_QUERY_APPEND;
      req_chan.code_point = '0;
      req_chan.last_char  = 1'b0;
      items_sent          = 0;
      steady              = 1'b0;
      osa_mode            = eds_pkg::MODE_RESET;
      query_len           = 0;
      query_cut           = 1'b0;
      clear_candidate_rows();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_strings();
      test_code_point_extremes();
      test_transpositions();
      test_mode_mid_candidate();
      test_abandon_and_end();
      test_query_overflow();
      test_candidate_overflow();
      test_random();

      settle();
      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
